// File: rtl/core/assert_macros.svh
// Assertion macros shared by the cross sharpen filter RTL.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define CSF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define CSF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/csf_pkg.sv
// Shared types and constants of the cross sharpen filter.
// No dependencies; imported by every module of the block but csf_ram.
package csf_pkg;

    localparam int PIX_W     = 8;
    localparam int ROW_W     = 12;
    localparam int COL_OUT_W = 10;
    localparam int FW_W      = 11;
    localparam int CWT_W     = 5;
    localparam int DIV_W     = 8;
    localparam int OFF_W     = 9;
    localparam int ACC_W     = 14;
    localparam int MAG_W     = 13;
    localparam int DCNT_W    = $clog2(MAG_W + 1);
    localparam int MIN_DIM   = 3;

    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_WEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIVISOR       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET        = 3'd4;

    localparam logic [FW_W-1:0]  RST_FRAME_WIDTH   = 11'd320;
    localparam logic [ROW_W-1:0] RST_FRAME_HEIGHT  = 12'd240;
    localparam logic [CWT_W-1:0] RST_CENTER_WEIGHT = 5'd8;
    localparam logic [DIV_W-1:0] RST_DIVISOR       = 8'd1;
    localparam logic [OFF_W-1:0] RST_OFFSET        = 9'h1E0;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    typedef struct packed {
        logic load;
        logic rd_next;
        logic cap_above;
        logic cap_right;
        logic calc;
        logic div_start;
        logic emit_first;
        logic emit_second;
    } t_cmd;

    typedef struct packed {
        logic do_filter;
        logic has_above;
        logic last_row;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

// File: rtl/core/csf_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module csf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/csf_div.sv
// Restoring divider of the kernel magnitude, one quotient bit per cycle.
// Depends on csf_pkg for widths and the assertion macros.
`include "assert_macros.svh"

module csf_div import csf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [MAG_W-1:0] i_dividend,
    input  logic [DIV_W-1:0] i_divisor,
    output logic [MAG_W-1:0] o_quotient,
    output logic             o_done
);

    logic [DIV_W-1:0]  r_rem;
    logic [MAG_W-1:0]  r_quo;
    logic [DIV_W-1:0]  r_den;
    logic [DCNT_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DIV_W:0]    trial;
    logic [DIV_W:0]    diff;
    logic              ge;
    logic [DIV_W-1:0]  n_rem;

    always_comb begin
        trial = {r_rem, r_quo[MAG_W-1]};
        diff  = trial - {1'b0, r_den};
        ge    = (trial >= {1'b0, r_den});
        n_rem = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_rem  <= '0;
            r_quo  <= i_dividend;
            r_den  <= i_divisor;
            r_cnt  <= DCNT_W'(MAG_W);
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[MAG_W-2:0], ge};
            r_cnt <= r_cnt - DCNT_W'(1);
            if (r_cnt == DCNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

    `CSF_ASSERT_IMPL(a_done_not_busy, i_clk, i_rst_n, o_done, !r_busy, "done while busy")
    `CSF_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_start, r_busy, "start did not set busy")

endmodule

// File: rtl/core/csf_datapath.sv
// Datapath: configuration registers, position counters, line store, kernel sum,
// divide, offset, clamp and the output register. Depends on csf_pkg, csf_ram, csf_div.
`include "assert_macros.svh"

module csf_datapath import csf_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [PIX_W-1:0]      i_pixel_in,
    input  t_cmd                  i_cmd,
    input  logic                  i_out_stall,
    output t_sts                  o_sts,
    output logic                  o_valid,
    output logic [PIX_W-1:0]      o_pixel_out,
    output logic [COL_OUT_W-1:0]  o_out_column,
    output logic [ROW_W-1:0]      o_out_row,
    output logic                  o_last_of_run
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WEW = $clog2(MAX_WIDTH + 1);
    localparam int WW  = (WEW > FW_W) ? WEW : FW_W;

    // configuration
    logic        [FW_W-1:0]  r_cfg_w;
    logic        [ROW_W-1:0] r_cfg_h;
    logic        [CWT_W-1:0] r_cfg_cw;
    logic        [DIV_W-1:0] r_cfg_div;
    logic signed [OFF_W-1:0] r_cfg_off;

    // position and pixel state
    logic [CW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    logic [CW-1:0]    r_x;
    logic [ROW_W-1:0] r_y;
    logic [PIX_W-1:0] r_pix;
    logic [PIX_W-1:0] r_above;
    logic [PIX_W-1:0] r_up;
    logic [PIX_W-1:0] r_left;
    logic [PIX_W-1:0] r_right;
    logic             r_right_ok;
    logic             r_do_filter;
    logic             r_has_above;
    logic             r_last;
    logic [ACC_W-1:0] r_acc;

    // output register
    logic                 r_out_valid;
    logic [PIX_W-1:0]     r_out_pix;
    logic [COL_OUT_W-1:0] r_out_col;
    logic [ROW_W-1:0]     r_out_row;
    logic                 r_out_last;

    // effective geometry
    logic [WW-1:0]    w_ext;
    logic [WW-1:0]    w_max;
    logic [WW-1:0]    w_eff;
    logic [ROW_W-1:0] h_eff;

    // position of the arriving pixel
    logic             col_wrap;
    logic [CW-1:0]    x0;
    logic [ROW_W-1:0] y0;
    logic [ROW_W-1:0] y_a;
    logic [CW:0]      x_p1;
    logic             x_p1_lt_w;
    logic             x_p2_le_w;
    logic             filt_a;
    logic [ROW_W-1:0] y_p1;
    logic [CW-1:0]    n_col;
    logic [ROW_W-1:0] n_row;

    // line store
    logic [CW-1:0]      x_nxt;
    logic [CW-1:0]      raddr;
    logic [2*PIX_W-1:0] rdata;

    // arithmetic
    logic [MAG_W-1:0]        prod;
    logic [ACC_W-1:0]        n_acc;
    logic [ACC_W-1:0]        acc_neg;
    logic [MAG_W-1:0]        mag;
    logic [DIV_W-1:0]        den;
    logic [MAG_W-1:0]        quo;
    logic                    div_done;
    logic signed [ACC_W:0]   q_s;
    logic signed [ACC_W:0]   sum;
    logic [PIX_W-1:0]        clamped;
    logic                    out_free;
    logic                    emit_any;

    always_comb begin
        w_ext = WW'(r_cfg_w);
        w_max = WW'(MAX_WIDTH);
        if (w_ext == '0) begin
            w_eff = WW'(1);
        end else if (w_ext > w_max) begin
            w_eff = w_max;
        end else begin
            w_eff = w_ext;
        end
        h_eff = (r_cfg_h == '0) ? ROW_W'(1) : r_cfg_h;
    end

    // Wrap stale counters against the current geometry before using them.
    always_comb begin
        col_wrap  = (WW'(r_col) >= w_eff);
        x0        = col_wrap ? '0 : r_col;
        y0        = col_wrap ? (r_row + ROW_W'(1)) : r_row;
        y_a       = (y0 >= h_eff) ? '0 : y0;
        x_p1      = {1'b0, x0} + (CW+1)'(1);
        x_p1_lt_w = (WW'(x_p1) < w_eff);
        x_p2_le_w = ((WW'(x_p1) + WW'(1)) <= w_eff);
        filt_a    = (w_eff >= WW'(MIN_DIM)) && (h_eff >= ROW_W'(MIN_DIM)) &&
                    (y_a >= ROW_W'(2)) && (x0 != '0) && x_p2_le_w;
        y_p1      = y_a + ROW_W'(1);
        if (x_p1_lt_w) begin
            n_col = x_p1[CW-1:0];
            n_row = y_a;
        end else begin
            n_col = '0;
            n_row = (y_p1 >= h_eff) ? '0 : y_p1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w   <= RST_FRAME_WIDTH;
            r_cfg_h   <= RST_FRAME_HEIGHT;
            r_cfg_cw  <= RST_CENTER_WEIGHT;
            r_cfg_div <= RST_DIVISOR;
            r_cfg_off <= RST_OFFSET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FRAME_WIDTH:   r_cfg_w   <= i_cfg_data[FW_W-1:0];
                REG_FRAME_HEIGHT:  r_cfg_h   <= i_cfg_data[ROW_W-1:0];
                REG_CENTER_WEIGHT: r_cfg_cw  <= i_cfg_data[CWT_W-1:0];
                REG_DIVISOR:       r_cfg_div <= i_cfg_data[DIV_W-1:0];
                REG_OFFSET:        r_cfg_off <= i_cfg_data[OFF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // word layout: row above in the upper byte, row two above in the lower byte
    assign x_nxt = r_x + CW'(1);
    assign raddr = (i_cmd.rd_next && r_right_ok) ? x_nxt : r_x;

    csf_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.cap_above),
        .i_waddr (r_x),
        .i_wdata ({r_pix, rdata[2*PIX_W-1:PIX_W]}),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        prod    = MAG_W'(r_cfg_cw) * MAG_W'(r_above);
        n_acc   = {1'b0, prod} - ACC_W'(r_left) - ACC_W'(r_right)
                - ACC_W'(r_up) - ACC_W'(r_pix);
        acc_neg = ~r_acc + ACC_W'(1);
        mag     = r_acc[ACC_W-1] ? acc_neg[MAG_W-1:0] : r_acc[MAG_W-1:0];
        den     = (r_cfg_div == '0) ? DIV_W'(1) : r_cfg_div;
    end

    csf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (mag),
        .i_divisor  (den),
        .o_quotient (quo),
        .o_done     (div_done)
    );

    // Apply the quotient sign, add the offset, clamp to a byte.
    always_comb begin
        q_s = r_acc[ACC_W-1] ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
        sum = q_s + (ACC_W+1)'(r_cfg_off);
        if (sum < 0) begin
            clamped = '0;
        end else if (sum > $signed((ACC_W+1)'(PIX_MAX))) begin
            clamped = PIX_MAX;
        end else begin
            clamped = sum[PIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_left <= '0;
        end else begin
            if (i_cmd.load) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (i_cmd.calc) begin
                r_left <= r_above;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x         <= x0;
            r_y         <= y_a;
            r_pix       <= i_pixel_in;
            r_right_ok  <= x_p1_lt_w;
            r_do_filter <= filt_a;
            r_has_above <= (y_a != '0);
            r_last      <= (y_a == h_eff - ROW_W'(1));
        end
        if (i_cmd.cap_above) begin
            r_above <= rdata[2*PIX_W-1:PIX_W];
            r_up    <= rdata[PIX_W-1:0];
        end
        if (i_cmd.cap_right) begin
            r_right <= r_right_ok ? rdata[2*PIX_W-1:PIX_W] : '0;
        end
        if (i_cmd.calc) begin
            r_acc <= n_acc;
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;
    assign emit_any = i_cmd.emit_first || i_cmd.emit_second;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_first || i_cmd.emit_second) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_first) begin
            r_out_pix  <= r_do_filter ? clamped : r_above;
            r_out_col  <= COL_OUT_W'(r_x);
            r_out_row  <= r_y - ROW_W'(1);
            r_out_last <= !r_last;
        end else if (i_cmd.emit_second) begin
            r_out_pix  <= r_pix;
            r_out_col  <= COL_OUT_W'(r_x);
            r_out_row  <= r_y;
            r_out_last <= 1'b1;
        end
    end

    always_comb begin
        o_sts.do_filter = r_do_filter;
        o_sts.has_above = r_has_above;
        o_sts.last_row  = r_last;
        o_sts.div_done  = div_done;
        o_sts.out_free  = out_free;
    end

    assign o_valid       = r_out_valid;
    assign o_pixel_out   = r_out_pix;
    assign o_out_column  = r_out_col;
    assign o_out_row     = r_out_row;
    assign o_last_of_run = r_out_last;

    `CSF_ASSERT_IMPL(a_first_above, i_clk, i_rst_n, i_cmd.emit_first, r_has_above, "no row above")
    `CSF_ASSERT_IMPL(a_emit_slot_free, i_clk, i_rst_n, emit_any, out_free, "output overwritten")

endmodule

// File: rtl/core/csf_ctrl.sv
// Controller state machine: sequences accept, line store reads, kernel sum,
// divide and result emission. Depends on csf_pkg and the assertion macros.
`include "assert_macros.svh"

module csf_ctrl import csf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output logic o_in_stall,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD0,
        S_RD1,
        S_RD2,
        S_MUL,
        S_DIV,
        S_WAIT,
        S_EMIT1,
        S_EMIT2
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_stall;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RD0;
                end
            end
            S_RD0: n_state = S_RD1;
            S_RD1: begin
                o_cmd.cap_above = 1'b1;
                o_cmd.rd_next   = 1'b1;
                n_state         = S_RD2;
            end
            S_RD2: begin
                o_cmd.cap_right = 1'b1;
                n_state         = S_MUL;
            end
            S_MUL: begin
                o_cmd.calc = 1'b1;
                n_state    = S_DIV;
            end
            S_DIV: begin
                // border pixels skip the divide
                if (i_sts.do_filter) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_WAIT;
                end else begin
                    n_state = S_EMIT1;
                end
            end
            S_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_EMIT1;
                end
            end
            S_EMIT1: begin
                if (!i_sts.has_above) begin
                    n_state = i_sts.last_row ? S_EMIT2 : S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.emit_first = 1'b1;
                    n_state          = i_sts.last_row ? S_EMIT2 : S_IDLE;
                end
            end
            S_EMIT2: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_second = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stall <= 1'b0;
        end else begin
            r_state <= n_state;
            r_stall <= (n_state != S_IDLE);
        end
    end

    assign o_in_stall = r_stall;

    `CSF_ASSERT_IMPL(a_accept_in_idle, i_clk, i_rst_n, (i_in_valid && !o_in_stall), (r_state == S_IDLE), "request taken outside idle")
    `CSF_ASSERT_IMPL(a_second_on_last, i_clk, i_rst_n, o_cmd.emit_second, i_sts.last_row, "copy emitted off last row")
    `CSF_ASSERT_NEXT(a_start_then_wait, i_clk, i_rst_n, o_cmd.div_start, (r_state == S_WAIT), "divide start lost")

endmodule

// File: rtl/core/cross_sharpen_filter.sv
// Top level of the cross sharpen filter: controller plus datapath.
// Depends on csf_pkg, csf_ctrl and csf_datapath.
//
//  channel  direction  handshake            payload
//  pixel    in         i_valid / o_stall    i_pixel_in
//  result   out        o_valid / i_stall    o_pixel_out, o_out_column, o_out_row, o_last_of_run
//  config   in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// One request at a time: a border or copied pixel goes through the read, kernel sum
// and emit states, a filtered pixel also waits on the bit-serial divider, the last row
// adds an emit state for the extra copy, and the result side can stall each emission.
// Reset is synchronous; it clears counters, left neighbour and registers to their
// defaults; the line store holds no reset and needs no clearing pass.
// A result waiting in the output register does not block the next pixel request.
module cross_sharpen_filter import csf_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [PIX_W-1:0]      i_pixel_in,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [PIX_W-1:0]      o_pixel_out,
    output logic [COL_OUT_W-1:0]  o_out_column,
    output logic [ROW_W-1:0]      o_out_row,
    output logic                  o_last_of_run
);

    t_cmd cmd;
    t_sts sts;

    csf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_sts      (sts),
        .o_in_stall (o_stall),
        .o_cmd      (cmd)
    );

    csf_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_pixel_in    (i_pixel_in),
        .i_cmd         (cmd),
        .i_out_stall   (i_stall),
        .o_sts         (sts),
        .o_valid       (o_valid),
        .o_pixel_out   (o_pixel_out),
        .o_out_column  (o_out_column),
        .o_out_row     (o_out_row),
        .o_last_of_run (o_last_of_run)
    );

endmodule

// File: verif/tb_cross_sharpen_filter.sv
// Self-checking testbench for cross_sharpen_filter: directed table, then random frames.
// Depends on csf_pkg and the cross_sharpen_filter RTL; results are checked by an
// in-bench model of the line stores, the cross kernel and the clamp.
module tb_cross_sharpen_filter;
    import csf_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int LINE_DEPTH     = 1024;
    localparam int WIDTH_REG_MAX  = (1 << FW_W) - 1;
    localparam int HEIGHT_REG_MAX = (1 << ROW_W) - 1;
    localparam int OFF_MASK       = (1 << OFF_W) - 1;
    localparam int DRAIN_CYCLES   = 40;
    localparam int RANDOM_ITEMS   = 1650;
    localparam int LONG_HOLD      = 400;
    localparam int WIDE_PHASE     = 2;
    localparam int TALL_PHASE     = 5;
    localparam int TALL_ROWS      = 6;
    localparam int TIMEOUT_CYCLES = 1000000;

    typedef struct packed {
        logic [PIX_W-1:0]     pix;
        logic [COL_OUT_W-1:0] col;
        logic [ROW_W-1:0]     row;
        logic                 last;
    } t_px_result;

    typedef enum logic {STEP_CFG, STEP_PIX} t_step_kind;

    typedef struct packed {
        t_step_kind            kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic                  typed;
        logic [1:0]            n_want;
        t_px_result [1:0]      want;
    } t_dir_step;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_stall;
    logic [PIX_W-1:0]      i_pixel_in;
    logic                  o_valid;
    logic                  i_stall;
    logic [PIX_W-1:0]      o_pixel_out;
    logic [COL_OUT_W-1:0]  o_out_column;
    logic [ROW_W-1:0]      o_out_row;
    logic                  o_last_of_run;

    // filter model state and its copy of the registers
    logic [PIX_W-1:0]        prev_line [LINE_DEPTH];
    logic [PIX_W-1:0]        cur_line [LINE_DEPTH];
    int                      col_cnt;
    int                      row_cnt;
    logic [PIX_W-1:0]        left_pix;
    logic [FW_W-1:0]         cfg_width;
    logic [ROW_W-1:0]        cfg_height;
    logic [CWT_W-1:0]        cfg_weight;
    logic [DIV_W-1:0]        cfg_div;
    logic signed [OFF_W-1:0] cfg_off;

    t_px_result pending_pixels[$];
    t_dir_step  script[$];
    int         mismatches;
    int         tx_idle_pct;
    int         rx_stall_pct;
    bit         long_hold;

    cross_sharpen_filter #(.MAX_WIDTH(LINE_DEPTH)) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_pixel_in   (i_pixel_in),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_pixel_out  (o_pixel_out),
        .o_out_column (o_out_column),
        .o_out_row    (o_out_row),
        .o_last_of_run(o_last_of_run)
    );

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic t_px_result px_res(input int p, input int c, input int r, input bit l);
        px_res = '{PIX_W'(p), COL_OUT_W'(c), ROW_W'(r), l};
    endfunction

    // Advance the filter model by one pixel; returns how many results it emits.
    function automatic int sharpen_step(input logic [PIX_W-1:0] pix,
                                        output t_px_result [1:0] emitted);
        int w, h, x, y, n, acc, dv;
        logic [PIX_W-1:0] above, up, left, right, outpix;
        logic last_row;
        emitted = '0;
        n = 0;
        w = cfg_width;
        if (w < 1) w = 1;
        if (w > LINE_DEPTH) w = LINE_DEPTH;
        h = cfg_height;
        if (h < 1) h = 1;
        // wrap counters left beyond a geometry that shrank
        if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt++;
        end
        if (row_cnt >= h) row_cnt = 0;
        x = col_cnt;
        y = row_cnt;
        last_row = (y == h - 1);
        above = cur_line[x];
        up = prev_line[x];
        left = left_pix;
        right = (x + 1 < w) ? cur_line[x + 1] : '0;
        if (y >= 1) begin
            outpix = above;
            if (w >= MIN_DIM && h >= MIN_DIM && y >= 2 && x >= 1 && x + 2 <= w) begin
                dv = (cfg_div == 0) ? 1 : int'(cfg_div);
                acc = int'(cfg_weight) * int'(above) - int'(left) - int'(right)
                      - int'(up) - int'(pix);
                acc = acc / dv + int'(cfg_off);
                if (acc < 0) outpix = '0;
                else if (acc > int'(PIX_MAX)) outpix = PIX_MAX;
                else outpix = PIX_W'(acc);
            end
            emitted[n] = px_res(outpix, x, y - 1, !last_row);
            n++;
        end
        if (last_row) begin
            emitted[n] = px_res(pix, x, y, 1'b1);
            n++;
        end
        left_pix = above;
        prev_line[x] = above;
        cur_line[x] = pix;
        col_cnt = x + 1;
        if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt = y + 1;
            if (row_cnt >= h) row_cnt = 0;
        end
        return n;
    endfunction

    function automatic t_dir_step cfg_step(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_step = '0;
        cfg_step.kind = STEP_CFG;
        cfg_step.idx = idx;
        cfg_step.data = CFG_DATA_W'(val);
    endfunction

    function automatic t_dir_step pix_step(input int val);
        pix_step = '0;
        pix_step.kind = STEP_PIX;
        pix_step.data = CFG_DATA_W'(val);
    endfunction

    function automatic t_dir_step pix_known(input int val, input int n,
                                            input t_px_result r0, input t_px_result r1);
        pix_known = pix_step(val);
        pix_known.typed = 1'b1;
        pix_known.n_want = 2'(n);
        pix_known.want = {r1, r0};
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel(input logic [PIX_W-1:0] level);
        case ($urandom_range(0, 7))
            0: pick_pixel = '0;
            1: pick_pixel = PIX_MAX;
            2, 3: pick_pixel = level;
            default: pick_pixel = PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            REG_FRAME_WIDTH:   cfg_width = data[FW_W-1:0];
            REG_FRAME_HEIGHT:  cfg_height = data[ROW_W-1:0];
            REG_CENTER_WEIGHT: cfg_weight = data[CWT_W-1:0];
            REG_DIVISOR:       cfg_div = data[DIV_W-1:0];
            REG_OFFSET:        cfg_off = data[OFF_W-1:0];
            default: ;
        endcase
    endtask

    // Drain every expected result, then let a row-0 pixel still in flight finish.
    task automatic wait_idle();
        i_valid = 1'b0;
        while (pending_pixels.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Offer one pixel request and hold it until accepted; called at a falling edge.
    task automatic send_pixel(input logic [PIX_W-1:0] pix, input bit typed, input int n_typed,
                              input t_px_result [1:0] typed_res);
        t_px_result [1:0] step_out;
        int n;
        while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_pixel_in = pix;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        n = sharpen_step(pix, step_out);
        if (typed) begin
            n = n_typed;
            step_out = typed_res;
        end
        for (int k = 0; k < n; k++) pending_pixels.push_back(step_out[k]);
        @(negedge i_clk);
    endtask

    task automatic run_phase(input int phase, output int counted);
        int w, h, w_eff, h_eff, frames, off;
        logic [PIX_W-1:0] level;
        case (phase % 4)
            0: begin
                tx_idle_pct = 0;
                rx_stall_pct = 0;
            end
            1: begin
                tx_idle_pct = 59;
                rx_stall_pct = 0;
            end
            2: begin
                tx_idle_pct = 0;
                rx_stall_pct = 59;
            end
            default: begin
                tx_idle_pct = 11;
                rx_stall_pct = 11;
            end
        endcase
        case ($urandom_range(0, 19))
            0: w = 0;
            1: w = 1;
            2: w = 2;
            default: w = $urandom_range(3, 10);
        endcase
        case ($urandom_range(0, 9))
            0: h = 0;
            1: h = 1;
            2: h = 2;
            default: h = $urandom_range(3, 8);
        endcase
        frames = $urandom_range(1, 3);
        if (phase == WIDE_PHASE) begin
            w = $urandom_range(0, 1) ? LINE_DEPTH : $urandom_range(LINE_DEPTH + 1, WIDTH_REG_MAX);
            h = $urandom_range(0, 1);
            frames = 1;
        end
        if (phase == TALL_PHASE) begin
            w = $urandom_range(0, 1);
            h = HEIGHT_REG_MAX;
        end
        case ($urandom_range(0, 5))
            0: off = -OFF_MASK / 2;
            1: off = OFF_MASK / 2;
            default: off = $urandom_range(0, OFF_MASK - 1) - OFF_MASK / 2;
        endcase
        wait_idle();
        write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
        case ($urandom_range(0, 4))
            0: write_reg(REG_CENTER_WEIGHT, '0);
            1: write_reg(REG_CENTER_WEIGHT, CFG_DATA_W'((1 << CWT_W) - 1));
            default: write_reg(REG_CENTER_WEIGHT, CFG_DATA_W'($urandom_range(0, 31)));
        endcase
        case ($urandom_range(0, 5))
            0: write_reg(REG_DIVISOR, '0);
            1: write_reg(REG_DIVISOR, CFG_DATA_W'(1));
            2: write_reg(REG_DIVISOR, CFG_DATA_W'((1 << DIV_W) - 1));
            3: write_reg(REG_DIVISOR, CFG_DATA_W'($urandom_range(1, 255)));
            default: write_reg(REG_DIVISOR, CFG_DATA_W'($urandom_range(1, 16)));
        endcase
        write_reg(REG_OFFSET, CFG_DATA_W'(off & OFF_MASK));
        // hold the result side off while requests keep coming
        if (phase % 4 == 0) long_hold = 1'b1;
        w_eff = (w < 1) ? 1 : ((w > LINE_DEPTH) ? LINE_DEPTH : w);
        h_eff = (h < 1) ? 1 : h;
        if (phase == TALL_PHASE) begin
            repeat (TALL_ROWS) send_pixel(pick_pixel(8'h80), 1'b0, 0, '0);
            // shrink the height below the current row so the next pixel starts a new frame
            wait_idle();
            write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(1));
            send_pixel(pick_pixel(8'h80), 1'b0, 0, '0);
            counted = TALL_ROWS + 1;
        end else begin
            repeat (frames) begin
                level = PIX_W'($urandom_range(0, 255));
                repeat (w_eff * h_eff) send_pixel(pick_pixel(level), 1'b0, 0, '0);
            end
            counted = frames * w_eff * h_eff;
        end
    endtask

    task automatic report_mismatch(input string what, input t_px_result want,
                                   input t_px_result got);
        mismatches++;
        if (mismatches <= 10)
            $display("%s: expected pix %0d col %0d row %0d last %0d, %s %0d col %0d row %0d last %0d",
                     what, want.pix, want.col, want.row, want.last, "got pix",
                     got.pix, got.col, got.row, got.last);
    endtask

    always @(posedge i_clk) begin : check_results
        t_px_result got;
        t_px_result want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            got = '{o_pixel_out, o_out_column, o_out_row, o_last_of_run};
            if (pending_pixels.size() == 0) begin
                report_mismatch("unexpected result", '0, got);
            end else begin
                want = pending_pixels.pop_front();
                if (got.pix !== want.pix || got.col !== want.col || got.row !== want.row
                    || got.last !== want.last)
                    report_mismatch("result mismatch", want, got);
            end
        end
    end

    // result side: random stall, or one long hold on request
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                long_hold = 1'b0;
                i_stall = 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
            end
            i_stall = (rx_stall_pct != 0) && ($urandom_range(0, 99) < rx_stall_pct);
        end
    end

    initial begin
        #(longint'(TIMEOUT_CYCLES) * CLK_PERIOD);
        $display("FAIL");
        $finish;
    end

    initial begin
        int phase;
        int sent;
        int random_items;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_pixel_in = '0;
        mismatches = 0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        long_hold = 1'b0;
        col_cnt = 0;
        row_cnt = 0;
        left_pix = '0;
        cfg_width = RST_FRAME_WIDTH;
        cfg_height = RST_FRAME_HEIGHT;
        cfg_weight = RST_CENTER_WEIGHT;
        cfg_div = RST_DIVISOR;
        cfg_off = RST_OFFSET;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset geometry: row 0 of a tall frame emits nothing
        script.push_back(pix_known(0, 0, '0, '0));
        script.push_back(pix_known(255, 0, '0, '0));
        // shrink width then height mid-row: both counters wrap into a one-row frame
        script.push_back(cfg_step(REG_FRAME_WIDTH, 1));
        script.push_back(cfg_step(REG_FRAME_HEIGHT, 1));
        script.push_back(pix_known(0, 1, px_res(0, 0, 0, 1), '0));
        script.push_back(pix_known(255, 1, px_res(255, 0, 0, 1), '0));
        // flat 3x3 frame with reset kernel: center is 8*10 - 4*10 - 32 = 8
        script.push_back(cfg_step(REG_FRAME_WIDTH, 3));
        script.push_back(cfg_step(REG_FRAME_HEIGHT, 3));
        for (int k = 0; k < 3; k++) script.push_back(pix_known(10, 0, '0, '0));
        for (int k = 0; k < 3; k++) script.push_back(pix_known(10, 1, px_res(10, k, 0, 1), '0));
        script.push_back(pix_known(10, 2, px_res(10, 0, 1, 0), px_res(10, 0, 2, 1)));
        script.push_back(pix_known(10, 2, px_res(8, 1, 1, 0), px_res(10, 1, 2, 1)));
        script.push_back(pix_known(10, 2, px_res(10, 2, 1, 0), px_res(10, 2, 2, 1)));
        // zero width acts as one column
        script.push_back(cfg_step(REG_FRAME_WIDTH, 0));
        script.push_back(cfg_step(REG_FRAME_HEIGHT, 2));
        script.push_back(pix_known(0, 0, '0, '0));
        script.push_back(pix_known(255, 2, px_res(0, 0, 0, 0), px_res(255, 0, 1, 1)));
        // zero height acts as one row
        script.push_back(cfg_step(REG_FRAME_WIDTH, 2));
        script.push_back(cfg_step(REG_FRAME_HEIGHT, 0));
        script.push_back(pix_known(7, 1, px_res(7, 0, 0, 1), '0));
        script.push_back(pix_known(200, 1, px_res(200, 1, 0, 1), '0));
        // heaviest kernel, zero divisor, largest offset: bright center clamps high
        script.push_back(cfg_step(REG_FRAME_WIDTH, 3));
        script.push_back(cfg_step(REG_FRAME_HEIGHT, 3));
        script.push_back(cfg_step(REG_CENTER_WEIGHT, 31));
        script.push_back(cfg_step(REG_DIVISOR, 0));
        script.push_back(cfg_step(REG_OFFSET, 255));
        for (int k = 0; k < 9; k++) script.push_back(pix_step(k == 4 ? 255 : 0));

        foreach (script[i]) begin
            if (script[i].kind == STEP_CFG) begin
                wait_idle();
                write_reg(script[i].idx, script[i].data);
            end else begin
                send_pixel(script[i].data[PIX_W-1:0], script[i].typed, script[i].n_want,
                           script[i].want);
            end
        end

        random_items = 0;
        phase = 0;
        while (random_items < RANDOM_ITEMS) begin
            run_phase(phase, sent);
            random_items += sent;
            phase++;
        end

        wait_idle();
        if (mismatches == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

endmodule
